/* rtl/highpass_notch_cascade_macros.svh */
// assertion macros used by the checker file of the high-pass and notch cascade
`ifndef HIGHPASS_NOTCH_CASCADE_MACROS_SVH
`define HIGHPASS_NOTCH_CASCADE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define HNC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hnc assertion failed");

// next-cycle implication, disabled while reset is low
`define HNC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hnc assertion failed");

`endif

/* rtl/hnc_pkg.sv */
// types and constants of the high-pass and notch cascade
`default_nettype none

package hnc_pkg;

  localparam int GAIN_BITS      = 17;
  localparam int COEF_BITS      = 19;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 19;

  localparam logic [GAIN_BITS-1:0] GAIN_RESET  = 17'd62259;
  localparam logic [GAIN_BITS-1:0] POLE2_RESET = 17'd58982;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_HP_GAIN    = 3'd0,
    REG_ZERO_COEF  = 3'd1,
    REG_POLE_COEF1 = 3'd2,
    REG_POLE_COEF2 = 3'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [GAIN_BITS-1:0] hp_gain;
    logic [COEF_BITS-1:0] zero_coef;
    logic [COEF_BITS-1:0] pole_coef1;
    logic [GAIN_BITS-1:0] pole_coef2;
  } coef_t;

endpackage

`default_nettype wire

/* rtl/hnc_round_sat.sv */
// round half up by a fraction shift, then saturate to the output width
`default_nettype none

module hnc_round_sat #(
  parameter int IN_BITS   = 40,
  parameter int FRAC_BITS = 16,
  parameter int OUT_BITS  = 24
) (
  input  logic signed [IN_BITS-1:0]  value_i,
  output logic signed [OUT_BITS-1:0] value_o
);

  localparam int SH_BITS  = IN_BITS + 1 - FRAC_BITS;
  localparam int EXT_BITS = ((SH_BITS > OUT_BITS) ? SH_BITS : OUT_BITS) + 1;

  localparam logic signed [IN_BITS:0] HALF =
    {{(IN_BITS + 1 - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
  localparam logic signed [EXT_BITS-1:0] MAXV =
    {{(EXT_BITS - OUT_BITS + 1){1'b0}}, {(OUT_BITS - 1){1'b1}}};
  localparam logic signed [EXT_BITS-1:0] MINV =
    {{(EXT_BITS - OUT_BITS + 1){1'b1}}, {(OUT_BITS - 1){1'b0}}};

  logic signed [IN_BITS:0]    rounded;
  logic signed [SH_BITS-1:0]  shifted;
  logic signed [EXT_BITS-1:0] wide;

  assign rounded = {value_i[IN_BITS-1], value_i} + HALF;
  // dropping the fraction bits is a floor shift
  assign shifted = rounded[IN_BITS:FRAC_BITS];
  assign wide    = EXT_BITS'(shifted);

  always_comb begin
    if (wide > MAXV) begin
      value_o = MAXV[OUT_BITS-1:0];
    end else if (wide < MINV) begin
      value_o = MINV[OUT_BITS-1:0];
    end else begin
      value_o = wide[OUT_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

/* rtl/hnc_datapath.sv */
// filter state and combinational high-pass plus notch arithmetic
`default_nettype none

module hnc_datapath import hnc_pkg::*; #(
  parameter int SAMPLE_BITS    = 16,
  parameter int STATE_BITS     = 24,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  coef_t                         coef_i,
  output logic signed [STATE_BITS-1:0]  sample_o
);

  localparam int SUM_BITS  = ((STATE_BITS > SAMPLE_BITS) ? STATE_BITS : SAMPLE_BITS) + 2;
  localparam int HP_BITS   = SUM_BITS + GAIN_BITS + 1;
  localparam int B1_BITS   = COEF_BITS + STATE_BITS;
  localparam int A2_BITS   = GAIN_BITS + 1 + STATE_BITS;
  localparam int ACC_BITS  =
    STATE_BITS + ((COEF_FRAC_BITS > COEF_BITS) ? COEF_FRAC_BITS : COEF_BITS) + 3;

  logic signed [SAMPLE_BITS-1:0] prev_raw_q;
  // the previous high-pass output is also the first notch input tap
  logic signed [STATE_BITS-1:0]  h1_q;
  logic signed [STATE_BITS-1:0]  h2_q;
  logic signed [STATE_BITS-1:0]  y1_q;
  logic signed [STATE_BITS-1:0]  y2_q;

  logic signed [SUM_BITS-1:0]  hp_sum;
  logic signed [GAIN_BITS:0]   gain_s;
  logic signed [HP_BITS-1:0]   hp_prod;
  logic signed [STATE_BITS-1:0] hp_out;

  logic signed [COEF_BITS-1:0] b1_s;
  logic signed [COEF_BITS-1:0] a1_s;
  logic signed [GAIN_BITS:0]   a2_s;
  logic signed [B1_BITS-1:0]   prod_b1;
  logic signed [B1_BITS-1:0]   prod_a1;
  logic signed [A2_BITS-1:0]   prod_a2;
  logic signed [ACC_BITS-1:0]  acc;

  assign hp_sum  = SUM_BITS'(h1_q) + SUM_BITS'(sample_i) - SUM_BITS'(prev_raw_q);
  assign gain_s  = $signed({1'b0, coef_i.hp_gain});
  assign hp_prod = gain_s * hp_sum;

  hnc_round_sat #(
    .IN_BITS  (HP_BITS),
    .FRAC_BITS(COEF_FRAC_BITS),
    .OUT_BITS (STATE_BITS)
  ) u_hp_round (
    .value_i(hp_prod),
    .value_o(hp_out)
  );

  assign b1_s    = $signed(coef_i.zero_coef);
  assign a1_s    = $signed(coef_i.pole_coef1);
  assign a2_s    = $signed({1'b0, coef_i.pole_coef2});
  // history products do not wait on the high-pass result
  assign prod_b1 = b1_s * h1_q;
  assign prod_a1 = a1_s * y1_q;
  assign prod_a2 = a2_s * y2_q;

  assign acc = (ACC_BITS'(hp_out) <<< COEF_FRAC_BITS)
             + (ACC_BITS'(h2_q) <<< COEF_FRAC_BITS)
             + ACC_BITS'(prod_b1)
             - ACC_BITS'(prod_a1)
             - ACC_BITS'(prod_a2);

  hnc_round_sat #(
    .IN_BITS  (ACC_BITS),
    .FRAC_BITS(COEF_FRAC_BITS),
    .OUT_BITS (STATE_BITS)
  ) u_notch_round (
    .value_i(acc),
    .value_o(sample_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_raw_q <= '0;
      h1_q       <= '0;
      h2_q       <= '0;
      y1_q       <= '0;
      y2_q       <= '0;
    end else if (step_i) begin
      prev_raw_q <= sample_i;
      h1_q       <= hp_out;
      h2_q       <= h1_q;
      y1_q       <= sample_o;
      y2_q       <= y1_q;
    end
  end

endmodule

`default_nettype wire

/* rtl/highpass_notch_cascade.sv */
// top level: high-pass then notch filter with input and result registers
//
//   channel  direction  handshake                payload
//   in       sink       in_valid_i / in_ready_o   sample_in_i
//   out      source     out_valid_o / out_ready_i sample_out_o
//   cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one sample per cycle sustained while the output is not stalled; a sample's
// beat loads the input register, from which the high-pass multiply plus the notch
// sum take the filter recursion into the result register, from which it can leave.
// reset clears the filter history and loads the default coefficients.
// a stalled output holds its result; one more sample waits in the input register.
// config beats are always taken and apply from the next cycle.
`default_nettype none

module highpass_notch_cascade import hnc_pkg::*; #(
  parameter int SAMPLE_BITS    = 16,
  parameter int STATE_BITS     = 24,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [STATE_BITS-1:0]  sample_out_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data_i
);

  logic                          in_valid_q;
  logic                          in_valid_d;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                          out_valid_q;
  logic                          out_valid_d;
  logic signed [STATE_BITS-1:0]  sample_out_q;
  logic signed [STATE_BITS-1:0]  filt_out;
  logic                          advance;
  logic                          in_beat;
  coef_t                         coef_q;
  coef_t                         coef_d;

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign in_beat     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign sample_out_o = sample_out_q;
  assign cfg_ready_o = 1'b1;

  assign in_valid_d  = in_beat || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !out_ready_i);

  always_comb begin
    coef_d = coef_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_HP_GAIN:    coef_d.hp_gain    = cfg_data_i[GAIN_BITS-1:0];
        REG_ZERO_COEF:  coef_d.zero_coef  = cfg_data_i[COEF_BITS-1:0];
        REG_POLE_COEF1: coef_d.pole_coef1 = cfg_data_i[COEF_BITS-1:0];
        REG_POLE_COEF2: coef_d.pole_coef2 = cfg_data_i[GAIN_BITS-1:0];
        default:        coef_d = coef_q;
      endcase
    end
  end

  hnc_datapath #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .STATE_BITS    (STATE_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .sample_i(sample_q),
    .coef_i  (coef_q),
    .sample_o(filt_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q         <= 1'b0;
      out_valid_q        <= 1'b0;
      coef_q.hp_gain     <= GAIN_RESET;
      coef_q.zero_coef   <= '0;
      coef_q.pole_coef1  <= '0;
      coef_q.pole_coef2  <= POLE2_RESET;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      coef_q      <= coef_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      sample_q <= sample_in_i;
    end
    if (advance) begin
      sample_out_q <= filt_out;
    end
  end

endmodule

`default_nettype wire

/* rtl/hnc_checker.sv */
// port-level checks of the high-pass and notch cascade, bound to the top level
`default_nettype none
`include "highpass_notch_cascade_macros.svh"

module hnc_checker #(
  parameter int STATE_BITS = 24
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [STATE_BITS-1:0] sample_out_o,
  input logic                  cfg_ready_o
);

  // a stalled result holds its value
  `HNC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(sample_out_o))

  // input back-pressure only comes from a stalled full output
  `HNC_ASSERT_IMP(a_ready_cause, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i)

  // a fresh result goes valid once its input beat has passed through the input register and the result register
  `HNC_ASSERT_IMP(a_latency, clk_i, rst_ni, $rose(out_valid_o), $past(in_valid_i && in_ready_o, 2))

  // config beats are never held off
  `HNC_ASSERT_IMP(a_cfg_ready, clk_i, rst_ni, 1'b1, cfg_ready_o)

endmodule

bind highpass_notch_cascade hnc_checker #(
  .STATE_BITS(STATE_BITS)
) u_hnc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .sample_out_o(sample_out_o),
  .cfg_ready_o (cfg_ready_o)
);

`default_nettype wire
